// ===== rtl/ile_pkg.sv =====
package ile_pkg;

  localparam int POS_W  = 9;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 9;
  localparam int STAT_W = 2;

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_INSERT_AT  = 4'd2,
    CMD_POP_FRONT  = 4'd3,
    CMD_POP_BACK   = 4'd4,
    CMD_REMOVE_AT  = 4'd5,
    CMD_READ_AT    = 4'd6,
    CMD_READ_FRONT = 4'd7,
    CMD_READ_BACK  = 4'd8
  } cmd_code_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // what a command does to the list
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PUT,
    KIND_TAKE,
    KIND_READ
  } op_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SHIFT,
    S_DRAIN,
    S_FINAL,
    S_RDWAIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [3:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         element_count;
    logic [STAT_W-1:0]        status;
  } rsp_t;

endpackage

// ===== rtl/ile_store.sv =====
module ile_store #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  logic [VALUE_BITS-1:0]       wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic [VALUE_BITS-1:0]       rd_data
);

  logic [VALUE_BITS-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ile_slot_add.sv =====
module ile_slot_add #(
  parameter int CAPACITY = 256
) (
  input  logic [$clog2(CAPACITY)-1:0]   base,
  input  logic [$clog2(CAPACITY+1)-1:0] offset,
  output logic [$clog2(CAPACITY)-1:0]   slot
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  logic [SW-1:0] raw;

  // base < capacity and offset <= capacity, so one subtract wraps it
  assign raw  = SW'(base) + SW'(offset);
  assign slot = (raw >= SW'(CAPACITY)) ? AW'(raw - SW'(CAPACITY)) : AW'(raw);

endmodule

// ===== rtl/ile_seq.sv =====
module ile_seq #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  ile_pkg::cmd_t               cmd,
  output logic                        idle,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ile_pkg::rsp_t               res,
  output logic                        mem_wr_en,
  output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
  output logic [VALUE_BITS-1:0]       mem_wr_data,
  output logic                        mem_rd_en,
  output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
  input  logic [VALUE_BITS-1:0]       mem_rd_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;
  localparam logic [CW-1:0] OFF_DEC = CW'(CAPACITY - 1);
  localparam logic [CW-1:0] OFF_INC = CW'(1);

  ile_pkg::seq_state_t state, state_next;
  ile_pkg::op_kind_t   kind, kind_next;
  ile_pkg::status_t    status, status_next, eval_st;

  logic [PW-1:0]                p, p_next;
  logic [VALUE_BITS-1:0]        val, val_next;
  logic [CW-1:0]                count, count_next;
  logic [AW-1:0]                head, head_next;
  logic [AW-1:0]                cursor, cursor_next;
  logic [CW-1:0]                moves, moves_next;
  logic                         wr_pend, wr_pend_next;
  logic [AW-1:0]                wr_tgt, wr_tgt_next;
  logic [ile_pkg::DATA_W-1:0]   rd_val, rd_val_next;

  logic [CW-1:0] p_cw;
  logic [PW-1:0] cnt_pw;
  logic [CW-1:0] move_cnt;
  logic          at_front;
  logic [AW-1:0] unit_base;
  logic [CW-1:0] unit_off;
  logic [AW-1:0] slot;

  // shared slot adder: list index to physical slot, and cursor stepping
  ile_slot_add #(.CAPACITY(CAPACITY)) u_slot (
    .base   (unit_base),
    .offset (unit_off),
    .slot   (slot)
  );

  assign p_cw     = CW'(p);
  assign cnt_pw   = PW'(count);
  assign at_front = (p == '0);
  assign move_cnt = (kind == ile_pkg::KIND_PUT) ? (count - p_cw) : (count - p_cw - CW'(1));

  always_comb begin
    case (kind) inside
      ile_pkg::KIND_PUT: begin
        if (count == CW'(CAPACITY))  eval_st = ile_pkg::STAT_FULL;
        else if (p > cnt_pw)         eval_st = ile_pkg::STAT_RANGE;
        else                         eval_st = ile_pkg::STAT_OK;
      end
      ile_pkg::KIND_TAKE, ile_pkg::KIND_READ: begin
        if (count == '0)             eval_st = ile_pkg::STAT_EMPTY;
        else if (p >= cnt_pw)        eval_st = ile_pkg::STAT_RANGE;
        else                         eval_st = ile_pkg::STAT_OK;
      end
      default:                       eval_st = ile_pkg::STAT_OK;
    endcase
  end

  always_comb begin
    if (state == ile_pkg::S_SHIFT) begin
      unit_base = cursor;
      unit_off  = (kind == ile_pkg::KIND_PUT) ? OFF_DEC : OFF_INC;
    end else begin
      unit_base = head;
      case (kind)
        ile_pkg::KIND_PUT:  unit_off = at_front ? OFF_DEC : count;
        ile_pkg::KIND_TAKE: unit_off = at_front ? OFF_INC : p_cw;
        default:            unit_off = p_cw;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ile_pkg::S_IDLE: begin
        if (start) state_next = ile_pkg::S_EVAL;
      end
      ile_pkg::S_EVAL: begin
        if (kind == ile_pkg::KIND_NONE || eval_st != ile_pkg::STAT_OK) begin
          state_next = ile_pkg::S_DONE;
        end else if (kind == ile_pkg::KIND_READ) begin
          state_next = ile_pkg::S_RDWAIT;
        end else if (at_front || move_cnt == '0) begin
          state_next = ile_pkg::S_FINAL;
        end else begin
          state_next = ile_pkg::S_SHIFT;
        end
      end
      ile_pkg::S_SHIFT: begin
        if (moves == CW'(1)) state_next = ile_pkg::S_DRAIN;
      end
      ile_pkg::S_DRAIN:  state_next = ile_pkg::S_FINAL;
      ile_pkg::S_FINAL:  state_next = ile_pkg::S_DONE;
      ile_pkg::S_RDWAIT: state_next = ile_pkg::S_DONE;
      ile_pkg::S_DONE: begin
        if (res_ready) state_next = ile_pkg::S_IDLE;
      end
      default: state_next = ile_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    kind_next    = kind;
    p_next       = p;
    val_next     = val;
    count_next   = count;
    head_next    = head;
    cursor_next  = cursor;
    moves_next   = moves;
    wr_pend_next = wr_pend;
    wr_tgt_next  = wr_tgt;
    status_next  = status;
    rd_val_next  = rd_val;
    idle         = 1'b0;
    res_valid    = 1'b0;
    mem_wr_en    = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = slot;
    mem_wr_addr  = (state == ile_pkg::S_FINAL) ? cursor : wr_tgt;
    mem_wr_data  = (state == ile_pkg::S_FINAL) ? val : mem_rd_data;
    unique case (state)
      ile_pkg::S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          val_next = VALUE_BITS'($signed(cmd.item_value));
          unique case (cmd.command) inside
            ile_pkg::CMD_PUSH_FRONT, ile_pkg::CMD_POP_FRONT, ile_pkg::CMD_READ_FRONT:
              p_next = '0;
            ile_pkg::CMD_PUSH_BACK:
              p_next = cnt_pw;
            ile_pkg::CMD_INSERT_AT, ile_pkg::CMD_REMOVE_AT, ile_pkg::CMD_READ_AT:
              p_next = PW'(cmd.position);
            ile_pkg::CMD_POP_BACK, ile_pkg::CMD_READ_BACK:
              p_next = cnt_pw - PW'(1);
            default:
              p_next = '0;
          endcase
          unique case (cmd.command) inside
            ile_pkg::CMD_PUSH_FRONT, ile_pkg::CMD_PUSH_BACK, ile_pkg::CMD_INSERT_AT:
              kind_next = ile_pkg::KIND_PUT;
            ile_pkg::CMD_POP_FRONT, ile_pkg::CMD_POP_BACK, ile_pkg::CMD_REMOVE_AT:
              kind_next = ile_pkg::KIND_TAKE;
            ile_pkg::CMD_READ_AT, ile_pkg::CMD_READ_FRONT, ile_pkg::CMD_READ_BACK:
              kind_next = ile_pkg::KIND_READ;
            default:
              kind_next = ile_pkg::KIND_NONE;
          endcase
        end
      end
      ile_pkg::S_EVAL: begin
        status_next  = eval_st;
        rd_val_next  = '0;
        wr_pend_next = 1'b0;
        if (eval_st == ile_pkg::STAT_OK) begin
          case (kind)
            ile_pkg::KIND_PUT: begin
              if (at_front) head_next = slot;
              cursor_next = slot;
              moves_next  = move_cnt;
            end
            ile_pkg::KIND_TAKE: begin
              if (at_front) head_next = slot;
              cursor_next = slot;
              moves_next  = move_cnt;
            end
            ile_pkg::KIND_READ: mem_rd_en = 1'b1;
            default: ;
          endcase
        end
      end
      ile_pkg::S_SHIFT: begin
        mem_rd_en    = 1'b1;
        mem_wr_en    = wr_pend;
        cursor_next  = slot;
        wr_tgt_next  = cursor;
        wr_pend_next = 1'b1;
        moves_next   = moves - CW'(1);
      end
      ile_pkg::S_DRAIN: begin
        mem_wr_en    = 1'b1;
        wr_pend_next = 1'b0;
      end
      ile_pkg::S_FINAL: begin
        if (kind == ile_pkg::KIND_PUT) begin
          mem_wr_en  = 1'b1;
          count_next = count + CW'(1);
        end else begin
          count_next = count - CW'(1);
        end
      end
      ile_pkg::S_RDWAIT: begin
        rd_val_next = ile_pkg::DATA_W'($signed(mem_rd_data));
      end
      ile_pkg::S_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ile_pkg::S_IDLE;
      count   <= '0;
      head    <= '0;
      wr_pend <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      head    <= head_next;
      wr_pend <= wr_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    kind   <= kind_next;
    p      <= p_next;
    val    <= val_next;
    cursor <= cursor_next;
    moves  <= moves_next;
    wr_tgt <= wr_tgt_next;
    status <= status_next;
    rd_val <= rd_val_next;
  end

  assign res.read_value    = rd_val;
  assign res.element_count = ile_pkg::CNT_W'(count);
  assign res.status        = status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_only_at_final: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(state) != ile_pkg::S_FINAL) |-> count == $past(count))
    else $error("count changed outside the final step");

  a_head_only_at_eval: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(state) != ile_pkg::S_EVAL) |-> head == $past(head))
    else $error("head moved outside the evaluate step");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_wr_en && mem_rd_en && mem_wr_addr == mem_rd_addr))
    else $error("shift reads the slot it writes");

endmodule

// ===== rtl/indexed_list_engine.sv =====
// indexed_list_engine: bounded ordered list of signed values in a circular store
//
// command channel (cmd_valid / cmd_ready / cmd): one item per command; push front
//   or back, insert at, pop front or back, remove at, read at, read front or back
// response channel (rsp_valid / rsp_ready / rsp): exactly one item per command with
//   the read value (zero unless a read succeeds), the count after it, and a status
// one command at a time: cmd_ready is high only while the sequencer is idle
// a failed or unused command, a read, or a push or pop at either end moves no entries;
//   insert or remove in the middle moves count - position entries on insert and
//   count - position - 1 on remove, at most CAPACITY-2 entries
// the moves run one entry per cycle over the store's read and write ports: read a
//   slot, then write that entry one slot over while the next read is issued
// puts and takes at the front move the head pointer instead of shifting
// rsp is a registered stage: a finished item waits there while the receiver
//   stalls; the sequencer holds its result until the stage frees, then takes
//   the next command
// reset clears count, head, the sequencer state, the pending-write flag and rsp_valid;
//   store contents are left as they are, since only entries inside the list are ever read
module indexed_list_engine #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  ile_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ile_pkg::rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic                  start;
  logic                  idle;
  logic                  res_valid;
  logic                  res_ready;
  ile_pkg::rsp_t         res;

  // store port
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [VALUE_BITS-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [VALUE_BITS-1:0] mem_rd_data;

  assign cmd_ready = idle;
  assign start     = cmd_valid && cmd_ready;

  // result moves into the output stage when it is empty or being drained
  assign res_ready = !rsp_valid || rsp_ready;

  ile_seq #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .idle        (idle),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ile_store #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule
